@@ design/yfp_pkg.sv @@
// shared constants, command and status types for the yuv frame psnr block
// used by yfp_ctrl, yfp_dp and yuv_frame_psnr
package yfp_pkg;

  localparam int unsigned DEF_COUNT_BITS = 24;
  localparam int unsigned SUM_W          = 40;
  localparam int unsigned SAMPLE_W       = 8;
  localparam int unsigned PSNR_W         = 16;
  localparam int unsigned MANT_W         = 32;
  localparam int unsigned FRAC_W         = 16;
  localparam int unsigned PEAK_SQ        = 65025;
  localparam int unsigned DB_PER_LOG2    = 197283;
  localparam int unsigned DB_W           = 18;
  localparam int unsigned ROUND_SHIFT    = 24;

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef struct packed {
    logic   acc_en;
    logic   mul_cnt;
    logic   load_x;
    logic   load_den;
    logic   norm_step;
    logic   load_mant;
    logic   sq_mul;
    logic   sq_norm;
    logic   save_ln;
    logic   diff_mul;
    logic   diff_fin;
    logic   set_inf;
    logic   out_load;
    plane_t plane;
  } yfp_cmd_t;

  typedef struct packed {
    logic inf_now;
    logic norm_done;
    logic out_free;
  } yfp_stat_t;

endpackage

@@ design/yfp_ctrl.sv @@
// sequencer for accumulation and the end-of-frame log2 / psnr evaluation
// depends on yfp_pkg
module yfp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  input  yfp_pkg::yfp_stat_t stat,
  output yfp_pkg::yfp_cmd_t  cmd
);
  import yfp_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN, ST_CHK, ST_MULC, ST_LOADX, ST_NORM, ST_SQM, ST_SQN,
    ST_LOGEND, ST_DFIN, ST_OUT
  } state_t;

  state_t      state_r, state_nxt;
  plane_t      plane_r, plane_nxt;
  logic        den_r, den_nxt;
  logic [3:0]  bit_r, bit_nxt;

  assign in_stall = (state_r != ST_RUN);

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    den_nxt   = den_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.plane = plane_r;
    cmd.load_den = den_r;
    unique case (state_r)
      ST_RUN: begin
        cmd.acc_en = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_CHK;
          plane_nxt = PLANE_Y;
        end
      end
      ST_CHK: begin
        if (stat.inf_now) begin
          cmd.set_inf = 1'b1;
          if (plane_r == PLANE_V) state_nxt = ST_OUT;
          else plane_nxt = plane_t'(plane_r + 2'd1);
        end else begin
          den_nxt   = 1'b0;
          state_nxt = ST_MULC;
        end
      end
      ST_MULC: begin
        cmd.mul_cnt = 1'b1;
        state_nxt   = ST_LOADX;
      end
      ST_LOADX: begin
        cmd.load_x = 1'b1;
        state_nxt  = ST_NORM;
      end
      ST_NORM: begin
        if (stat.norm_done) begin
          cmd.load_mant = 1'b1;
          bit_nxt       = '0;
          state_nxt     = ST_SQM;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      ST_SQM: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = ST_SQN;
      end
      ST_SQN: begin
        cmd.sq_norm = 1'b1;
        if (bit_r == 4'd15) begin
          state_nxt = ST_LOGEND;
        end else begin
          bit_nxt   = bit_r + 4'd1;
          state_nxt = ST_SQM;
        end
      end
      ST_LOGEND: begin
        if (!den_r) begin
          cmd.save_ln = 1'b1;
          den_nxt     = 1'b1;
          state_nxt   = ST_LOADX;
        end else begin
          cmd.diff_mul = 1'b1;
          state_nxt    = ST_DFIN;
        end
      end
      ST_DFIN: begin
        cmd.diff_fin = 1'b1;
        if (plane_r == PLANE_V) begin
          state_nxt = ST_OUT;
        end else begin
          plane_nxt = plane_t'(plane_r + 2'd1);
          state_nxt = ST_CHK;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      plane_r <= PLANE_Y;
      den_r   <= 1'b0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      den_r   <= den_nxt;
      bit_r   <= bit_nxt;
    end
  end

endmodule

@@ design/yfp_dp.sv @@
// datapath: squared-difference accumulators, shared log2 unit, psnr scaling
// and the output register; depends on yfp_pkg
module yfp_dp #(
  parameter int unsigned COUNT_BITS = yfp_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  yfp_pkg::yfp_cmd_t              cmd,
  output yfp_pkg::yfp_stat_t             stat,
  input  logic                           in_is_chroma,
  input  logic [yfp_pkg::SAMPLE_W-1:0]   in_left_first,
  input  logic [yfp_pkg::SAMPLE_W-1:0]   in_right_first,
  input  logic [yfp_pkg::SAMPLE_W-1:0]   in_left_second,
  input  logic [yfp_pkg::SAMPLE_W-1:0]   in_right_second,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [yfp_pkg::PSNR_W-1:0]     out_psnr_y,
  output logic [yfp_pkg::PSNR_W-1:0]     out_psnr_u,
  output logic [yfp_pkg::PSNR_W-1:0]     out_psnr_v,
  output logic                           out_inf_y,
  output logic                           out_inf_u,
  output logic                           out_inf_v,
  output logic [yfp_pkg::SUM_W-1:0]      out_sum_sq_y,
  output logic [yfp_pkg::SUM_W-1:0]      out_sum_sq_u,
  output logic [yfp_pkg::SUM_W-1:0]      out_sum_sq_v
);
  import yfp_pkg::*;

  localparam int unsigned NUM_W = COUNT_BITS + 16;
  localparam int unsigned XW    = (NUM_W > SUM_W) ? NUM_W : SUM_W;
  localparam int unsigned PW    = $clog2(XW);
  localparam int unsigned LW    = PW + FRAC_W;
  localparam int unsigned DW    = LW + DB_W;
  localparam int unsigned VW    = DW + 1 - ROUND_SHIFT;

  logic [SUM_W-1:0]      sse_y_r, sse_u_r, sse_v_r;
  logic [COUNT_BITS-1:0] cnt_y_r, cnt_c_r;
  logic [NUM_W-1:0]      num_r;
  logic [XW-1:0]         x_r;
  logic [PW-1:0]         p_r;
  logic [MANT_W-1:0]     m_r;
  logic [2*MANT_W-1:0]   prod_r;
  logic [FRAC_W-1:0]     frac_r;
  logic [LW-1:0]         ln_r;
  logic [DW-1:0]         dprod_r;
  logic [PSNR_W-1:0]     psnr_r [3];
  logic [2:0]            inf_r;
  logic                  out_valid_r;

  logic [SUM_W-1:0]      sse_sel;
  logic [COUNT_BITS-1:0] cnt_sel;
  logic [LW-1:0]         ld;
  logic [MANT_W:0]       sq_top;
  logic [DW:0]           vfull;
  logic [VW-1:0]         v;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [SAMPLE_W-1:0] a,
                                               input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0]   d;
    logic [2*SAMPLE_W-1:0] sq;
    logic [SUM_W:0]        s;
    d  = (a >= b) ? (a - b) : (b - a);
    sq = d * d;
    s  = {1'b0, acc} + {{(SUM_W + 1 - 2*SAMPLE_W){1'b0}}, sq};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  always_comb begin
    unique case (cmd.plane)
      PLANE_Y: begin sse_sel = sse_y_r; cnt_sel = cnt_y_r; end
      PLANE_U: begin sse_sel = sse_u_r; cnt_sel = cnt_c_r; end
      default: begin sse_sel = sse_v_r; cnt_sel = cnt_c_r; end
    endcase
  end

  assign ld     = {p_r, frac_r};
  assign sq_top = prod_r[2*MANT_W-1:MANT_W-1];
  assign vfull  = {1'b0, dprod_r} + (DW+1)'(1 << (ROUND_SHIFT - 1));
  assign v      = vfull[DW:ROUND_SHIFT];

  assign stat.inf_now   = (sse_sel == '0) || (cnt_sel == '0);
  assign stat.norm_done = x_r[XW-1];
  assign stat.out_free  = !out_valid_r || !out_stall;

  // accumulators and counts
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.out_load) begin
      sse_y_r <= '0;
      sse_u_r <= '0;
      sse_v_r <= '0;
      cnt_y_r <= '0;
      cnt_c_r <= '0;
    end else if (cmd.acc_en) begin
      if (in_is_chroma) begin
        sse_u_r <= sat_add(sse_u_r, in_left_first, in_right_first);
        sse_v_r <= sat_add(sse_v_r, in_left_second, in_right_second);
        if (cnt_c_r != {COUNT_BITS{1'b1}}) cnt_c_r <= cnt_c_r + COUNT_BITS'(1);
      end else begin
        sse_y_r <= sat_add(sse_y_r, in_left_first, in_right_first);
        if (cnt_y_r != {COUNT_BITS{1'b1}}) cnt_y_r <= cnt_y_r + COUNT_BITS'(1);
      end
    end
  end

  // shared log2 unit: normalize one bit a cycle, then square-and-halve
  always_ff @(posedge clk) begin
    if (cmd.mul_cnt) num_r <= NUM_W'(cnt_sel) * NUM_W'(PEAK_SQ);
    if (cmd.load_x) begin
      x_r <= cmd.load_den ? XW'(sse_sel) : XW'(num_r);
      p_r <= PW'(XW - 1);
    end else if (cmd.norm_step) begin
      x_r <= {x_r[XW-2:0], 1'b0};
      p_r <= p_r - PW'(1);
    end
    if (cmd.load_mant) begin
      m_r    <= x_r[XW-1 -: MANT_W];
      frac_r <= '0;
    end else if (cmd.sq_norm) begin
      frac_r <= {frac_r[FRAC_W-2:0], sq_top[MANT_W]};
      m_r    <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
    end
    if (cmd.sq_mul) prod_r <= {{MANT_W{1'b0}}, m_r} * {{MANT_W{1'b0}}, m_r};
    if (cmd.save_ln) ln_r <= ld;
    if (cmd.diff_mul) begin
      dprod_r <= (ln_r > ld) ? (DW'(ln_r - ld) * DW'(DB_PER_LOG2)) : '0;
    end
    if (cmd.set_inf) begin
      psnr_r[cmd.plane] <= '0;
      inf_r[cmd.plane]  <= 1'b1;
    end else if (cmd.diff_fin) begin
      psnr_r[cmd.plane] <= (v[VW-1:PSNR_W] != '0) ? {PSNR_W{1'b1}} : v[PSNR_W-1:0];
      inf_r[cmd.plane]  <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_psnr_y   <= psnr_r[PLANE_Y];
      out_psnr_u   <= psnr_r[PLANE_U];
      out_psnr_v   <= psnr_r[PLANE_V];
      out_inf_y    <= inf_r[PLANE_Y];
      out_inf_u    <= inf_r[PLANE_U];
      out_inf_v    <= inf_r[PLANE_V];
      out_sum_sq_y <= sse_y_r;
      out_sum_sq_u <= sse_u_r;
      out_sum_sq_v <= sse_v_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/yuv_frame_psnr.sv @@
// top level of the per-plane psnr block for two streamed 8-bit yuv frames
// depends on yfp_pkg, yfp_ctrl and yfp_dp
//
// input channel: in_valid / in_stall plus one port per field. a luma
// transaction adds one Y squared difference, a chroma transaction one U and
// one V squared difference. sums saturate at 2^40-1, counts at
// 2^COUNT_BITS-1. items stream at one transaction per cycle while in_stall
// is low. the transaction with in_last set closes the frame: in_stall rises
// and a shared log2 unit evaluates up to six logs (one bit of normalization
// per cycle, then 16 square-and-halve steps). the log operand width XW is 40
// at the default count width; a plane with zero sum or count skips its logs
// and is flagged infinite.
// result channel: out_valid / out_stall, one transaction per frame. the
// result sits in an output register; while the receiver stalls, a finished
// frame waits there and the block holds in_stall until it can load it.
// loading the result clears the accumulators and reopens the input.
// reset (synchronous, rst_n low) clears accumulators, counts and out_valid.
module yuv_frame_psnr #(
  parameter int unsigned COUNT_BITS = yfp_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_is_chroma,
  input  logic [yfp_pkg::SAMPLE_W-1:0] in_left_first,
  input  logic [yfp_pkg::SAMPLE_W-1:0] in_right_first,
  input  logic [yfp_pkg::SAMPLE_W-1:0] in_left_second,
  input  logic [yfp_pkg::SAMPLE_W-1:0] in_right_second,
  input  logic                         in_last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [yfp_pkg::PSNR_W-1:0]   out_psnr_y,
  output logic [yfp_pkg::PSNR_W-1:0]   out_psnr_u,
  output logic [yfp_pkg::PSNR_W-1:0]   out_psnr_v,
  output logic                         out_inf_y,
  output logic                         out_inf_u,
  output logic                         out_inf_v,
  output logic [yfp_pkg::SUM_W-1:0]    out_sum_sq_y,
  output logic [yfp_pkg::SUM_W-1:0]    out_sum_sq_u,
  output logic [yfp_pkg::SUM_W-1:0]    out_sum_sq_v
);
  import yfp_pkg::*;

  yfp_cmd_t  cmd;
  yfp_stat_t stat;

  yfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  yfp_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_is_chroma    (in_is_chroma),
    .in_left_first   (in_left_first),
    .in_right_first  (in_right_first),
    .in_left_second  (in_left_second),
    .in_right_second (in_right_second),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_psnr_y      (out_psnr_y),
    .out_psnr_u      (out_psnr_u),
    .out_psnr_v      (out_psnr_v),
    .out_inf_y       (out_inf_y),
    .out_inf_u       (out_inf_u),
    .out_inf_v       (out_inf_v),
    .out_sum_sq_y    (out_sum_sq_y),
    .out_sum_sq_u    (out_sum_sq_u),
    .out_sum_sq_v    (out_sum_sq_v)
  );

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");

  a_load_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> in_stall)
    else $error("transaction accepted while loading a result");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> stat.inf_now)
    else $error("accumulators not cleared after result load");

  a_no_accum_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cmd.acc_en)
    else $error("accumulation while evaluating a frame");
`endif

endmodule
